@@ src/cpu_divide_unit_8_16_top_assert.svh @@
// assertion macros for the divide unit checks
`ifndef CPU_DIVIDE_UNIT_8_16_TOP_ASSERT_SVH
`define CPU_DIVIDE_UNIT_8_16_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define CDU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CDU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cdu_pkg.sv @@
// shared types and constants for the divide unit
`timescale 1ns / 1ps

package cdu_pkg;

    localparam int CDU_DVD_W           = 32;
    localparam int CDU_DVS_W           = 16;
    localparam int CDU_STEPS_PER_STAGE = 4;
    localparam int CDU_S_TDATA_W       = 48;
    localparam int CDU_S_TUSER_W       = 2;
    localparam int CDU_M_TDATA_W       = 40;

    // one item in flight through the divide stages
    typedef struct packed {
        logic [15:0] rem;       // partial remainder
        logic [31:0] dq;        // dividend shifting out, quotient shifting in
        logic [15:0] dvs;       // divisor magnitude
        logic        req_type;
        logic        word_size;
        logic        neg_q;
        logic        neg_r;
        logic        zero_dvs;
        logic [15:0] zero_q;
        logic [15:0] zero_r;
    } cdu_work_t;

    typedef struct packed {
        logic        overflow;
        logic [15:0] remainder;
        logic [15:0] quotient;
    } cdu_result_t;

endpackage

@@ src/cpu_divide_unit_8_16_top.sv @@
// top level of the pipelined 16/8 and 32/16 divide unit
//
//  chan | dir | tdata (low bit up)                                  | tuser (low bit up)
//  -----+-----+-----------------------------------------------------+--------------------------
//  s_   | in  | dividend[31:0], divisor[47:32]                      | req_type[0], word_size[1]
//  m_   | out | quotient[15:0], remainder[31:16], ovf[32], 0[39:33] | none
//
// one beat accepted per cycle unless a stall on m_ has backed up to s_; a beat passes through
// the entry stage, the restoring divide stages at STEPS_PER_STAGE bits each, and the exit stage
// every stage holds its own valid bit and loads when empty or when the next one drains,
// so bubbles close up and a stall on m_ backs up stage by stage with nothing lost
// reset (aresetn low, synchronous) clears the valid bits only; the unit keeps no state
`timescale 1ns / 1ps

`include "cpu_divide_unit_8_16_top_assert.svh"

module cpu_divide_unit_8_16_top import cdu_pkg::*; #(
    parameter int STEPS_PER_STAGE = CDU_STEPS_PER_STAGE
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input beats
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [CDU_S_TDATA_W-1:0] s_tdata,   // dividend[31:0], divisor[47:32]
    input  logic [CDU_S_TUSER_W-1:0] s_tuser,   // req_type[0], word_size[1]
    // result beats
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [CDU_M_TDATA_W-1:0] m_tdata    // quotient[15:0], remainder[31:16],
                                                // overflow[32], zeros[39:33]
);

    // number of divide stages, one quotient bit per step
    localparam int NUM_STAGES = CDU_DVD_W / STEPS_PER_STAGE;

    logic [NUM_STAGES:0] chain_valid;
    logic [NUM_STAGES:0] chain_ready;
    cdu_work_t           chain_work [NUM_STAGES+1];
    cdu_result_t         result;

    // checker helpers: beat entering the exit stage and the result beat it leaves as
    logic                post_take;
    logic                post_zero;
    logic                post_byte;
    logic                m_ovf;
    logic                m_upper_zero;

    // operand decode and magnitudes
    cdu_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser[0]),
        .word_size (s_tuser[1]),
        .dividend  (s_tdata[31:0]),
        .divisor   (s_tdata[47:32]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_work  (chain_work[0])
    );

    // restoring divide, msb of the quotient first
    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        cdu_div_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    // signs, width cut, overflow and the output register
    cdu_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[NUM_STAGES]),
        .in_ready   (chain_ready[NUM_STAGES]),
        .in_work    (chain_work[NUM_STAGES]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {7'b000_0000, result.overflow, result.remainder, result.quotient};

    assign post_take    = chain_valid[NUM_STAGES] && chain_ready[NUM_STAGES];
    assign post_zero    = post_take && chain_work[NUM_STAGES].zero_dvs;
    assign post_byte    = post_take && !chain_work[NUM_STAGES].word_size;
    assign m_ovf        = m_tvalid && m_tdata[32];
    assign m_upper_zero = m_tvalid && (m_tdata[15:8] == 8'h00) && (m_tdata[31:24] == 8'h00);

    // an empty output register means every stage can take a beat
    `CDU_ASSERT_NOW(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready, "stall when empty")

    // a zero divisor always leaves with overflow set
    `CDU_ASSERT_NEXT(a_zero_div_ovf, aclk, aresetn, post_zero, m_ovf, "zero divisor, no ovf")

    // byte mode clears the upper bytes of quotient and remainder
    `CDU_ASSERT_NEXT(a_byte_upper_zero, aclk, aresetn, post_byte, m_upper_zero, "byte upper set")

endmodule

@@ src/cdu_prep.sv @@
// entry stage: operand selection, magnitudes and zero-divisor values
`timescale 1ns / 1ps

module cdu_prep import cdu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic        word_size,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        out_valid,
    input  logic        out_ready,
    output cdu_work_t   out_work
);

    logic        valid_reg;
    cdu_work_t   work_reg;
    cdu_work_t   work_next;
    logic [31:0] dvd_raw;
    logic [31:0] dvd_sext;
    logic [15:0] dvs_raw;
    logic [15:0] dvs_sext;
    logic        sign_a;
    logic        sign_b;
    logic        neg_a;
    logic        neg_b;

    always_comb begin
        dvd_raw  = word_size ? dividend : {16'h0000, dividend[15:0]};
        dvd_sext = word_size ? dividend : {{16{dividend[15]}}, dividend[15:0]};
        dvs_raw  = word_size ? divisor : {8'h00, divisor[7:0]};
        dvs_sext = word_size ? divisor : {{8{divisor[7]}}, divisor[7:0]};
        sign_a   = word_size ? dividend[31] : dividend[15];
        sign_b   = word_size ? divisor[15] : divisor[7];
        neg_a    = req_type & sign_a;
        neg_b    = req_type & sign_b;

        work_next           = '0;
        work_next.rem       = 16'h0000;
        work_next.dq        = neg_a ? (32'h0000_0000 - dvd_sext) : dvd_raw;
        work_next.dvs       = neg_b ? (16'h0000 - dvs_sext) : dvs_raw;
        work_next.req_type  = req_type;
        work_next.word_size = word_size;
        work_next.neg_q     = neg_a ^ neg_b;
        work_next.neg_r     = neg_a;
        work_next.zero_dvs  = (dvs_raw == 16'h0000);
        work_next.zero_q    = word_size ? ~dividend[31:16] : {8'h00, ~dividend[15:8]};
        work_next.zero_r    = word_size ? dividend[15:0] : {8'h00, dividend[7:0]};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

@@ src/cdu_div_stage.sv @@
// one pipeline stage of restoring division, STEPS quotient bits per stage
`timescale 1ns / 1ps

module cdu_div_stage import cdu_pkg::*; #(
    parameter int STEPS = CDU_STEPS_PER_STAGE
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cdu_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output cdu_work_t out_work
);

    logic        valid_reg;
    cdu_work_t   work_reg;
    cdu_work_t   work_next;
    logic [16:0] trial;
    logic [17:0] diff;
    logic        fits;

    always_comb begin
        work_next = in_work;
        trial     = '0;
        diff      = '0;
        fits      = 1'b0;
        for (int i = 0; i < STEPS; i++) begin
            trial        = {work_next.rem, work_next.dq[31]};
            diff         = {1'b0, trial} - {2'b00, work_next.dvs};
            fits         = !diff[17];
            work_next.rem = fits ? diff[15:0] : trial[15:0];
            work_next.dq  = {work_next.dq[30:0], fits};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

@@ src/cdu_post.sv @@
// exit stage: sign fix-up, width cut, overflow and output register
`timescale 1ns / 1ps

module cdu_post import cdu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cdu_work_t   in_work,
    output logic        out_valid,
    input  logic        out_ready,
    output cdu_result_t out_result
);

    logic        valid_reg;
    cdu_result_t result_reg;
    cdu_result_t result_next;
    logic [31:0] q_signed;
    logic [15:0] r_signed;
    logic [31:0] q_limit;
    logic        ovf_signed;
    logic        ovf_unsigned;

    always_comb begin
        q_signed     = in_work.neg_q ? (32'h0000_0000 - in_work.dq) : in_work.dq;
        r_signed     = in_work.neg_r ? (16'h0000 - in_work.rem) : in_work.rem;
        q_limit      = in_work.word_size ? 32'h0000_8000 : 32'h0000_0080;
        ovf_signed   = in_work.neg_q ? (in_work.dq > q_limit) : (in_work.dq >= q_limit);
        ovf_unsigned = in_work.word_size ? (|in_work.dq[31:16]) : (|in_work.dq[31:8]);

        result_next = '0;
        if (in_work.zero_dvs) begin
            result_next.quotient  = in_work.zero_q;
            result_next.remainder = in_work.zero_r;
            result_next.overflow  = 1'b1;
        end else begin
            result_next.quotient  = in_work.word_size ? q_signed[15:0]
                                                      : {8'h00, q_signed[7:0]};
            result_next.remainder = in_work.word_size ? r_signed
                                                      : {8'h00, r_signed[7:0]};
            result_next.overflow  = in_work.req_type ? ovf_signed : ovf_unsigned;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule

@@ dv/tb_cpu_divide_unit_8_16_top.sv @@
// self-checking testbench for the 16/8 and 32/16 divide unit
`timescale 1ns / 1ps

module tb_cpu_divide_unit_8_16_top;
    import cdu_pkg::*;

    localparam bit OP_UNSIGNED = 1'b0;
    localparam bit OP_SIGNED   = 1'b1;
    localparam bit SIZE_BYTE   = 1'b0;
    localparam bit SIZE_WORD   = 1'b1;

    localparam int DUT_LATENCY    = 2 + 32 / CDU_STEPS_PER_STAGE;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_ROWS         = 25;

    // one directed divide; has_ans marks a row whose result is typed in
    typedef struct packed {
        logic        sgn;
        logic        wide;
        logic [31:0] dvd;
        logic [15:0] dvs;
        logic        has_ans;
        cdu_result_t ans;
    } div_row_t;

    // result patterns are {overflow, remainder, quotient}
    localparam div_row_t DIR_ROWS [N_ROWS] = '{
        // zero divisor: inverted high half and low half, both modes
        '{OP_UNSIGNED, SIZE_BYTE, 32'h0000_0000, 16'h0000, 1'b1, '{1'b1, 16'h0000, 16'h00FF}},
        '{OP_UNSIGNED, SIZE_BYTE, 32'h0000_FFFF, 16'hFF00, 1'b1, '{1'b1, 16'h00FF, 16'h0000}},
        '{OP_SIGNED,   SIZE_WORD, 32'h1234_5678, 16'h0000, 1'b1, '{1'b1, 16'h5678, 16'hEDCB}},
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_8001, 16'h0000, 1'b1, '{1'b1, 16'h0001, 16'h007F}},
        // unsigned extremes and quotient overflow
        '{OP_UNSIGNED, SIZE_WORD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b1, 16'h0000, 16'h0001}},
        '{OP_UNSIGNED, SIZE_BYTE, 32'h0000_00FF, 16'h0001, 1'b1, '{1'b0, 16'h0000, 16'h00FF}},
        '{OP_UNSIGNED, SIZE_BYTE, 32'h0000_0100, 16'h0001, 1'b1, '{1'b1, 16'h0000, 16'h0000}},
        // most negative dividend over minus one
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_8000, 16'h00FF, 1'b1, '{1'b1, 16'h0000, 16'h0000}},
        '{OP_SIGNED,   SIZE_WORD, 32'h8000_0000, 16'hFFFF, 1'b1, '{1'b1, 16'h0000, 16'h0000}},
        // signed range edges
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_FF80, 16'h0001, 1'b1, '{1'b0, 16'h0000, 16'h0080}},
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_0080, 16'h0001, 1'b1, '{1'b1, 16'h0000, 16'h0080}},
        // truncation toward zero, remainder takes the dividend's sign
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_FFF9, 16'h0002, 1'b1, '{1'b0, 16'h00FF, 16'h00FD}},
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_0007, 16'h00FE, 1'b1, '{1'b0, 16'h0001, 16'h00FD}},
        '{OP_SIGNED,   SIZE_WORD, 32'hFFFF_FFF9, 16'h0002, 1'b1, '{1'b0, 16'hFFFF, 16'hFFFD}},
        '{OP_UNSIGNED, SIZE_WORD, 32'h0000_0000, 16'h0001, 1'b1, '{1'b0, 16'h0000, 16'h0000}},
        // byte mode ignores the upper bits of both operands, then the word-mode signed limit
        '{OP_UNSIGNED, SIZE_BYTE, 32'hABCD_0064, 16'h1207, 1'b1, '{1'b0, 16'h0002, 16'h000E}},
        '{OP_SIGNED,   SIZE_WORD, 32'h7FFF_FFFF, 16'h0001, 1'b1, '{1'b1, 16'h0000, 16'hFFFF}},
        '{OP_SIGNED,   SIZE_WORD, 32'h0000_7FFF, 16'h0001, 1'b1, '{1'b0, 16'h0000, 16'h7FFF}},
        // left to the predictor
        '{OP_UNSIGNED, SIZE_WORD, 32'h0001_FFFE, 16'h0002, 1'b0, '0},
        '{OP_SIGNED,   SIZE_WORD, 32'hC000_0000, 16'h8000, 1'b0, '0},
        '{OP_SIGNED,   SIZE_BYTE, 32'h0000_C000, 16'h0080, 1'b0, '0},
        '{OP_UNSIGNED, SIZE_WORD, 32'hFFFE_0001, 16'hFFFF, 1'b0, '0},
        '{OP_UNSIGNED, SIZE_BYTE, 32'hFFFF_FE01, 16'h00FF, 1'b0, '0},
        '{OP_SIGNED,   SIZE_WORD, 32'h8000_0001, 16'h7FFF, 1'b0, '0},
        '{OP_SIGNED,   SIZE_BYTE, 32'h5A5A_A5A5, 16'h3CC3, 1'b0, '0}
    };

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [CDU_S_TDATA_W-1:0] s_tdata  = '0;
    logic [CDU_S_TUSER_W-1:0] s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [CDU_M_TDATA_W-1:0] m_tdata;

    // results still owed by the unit, oldest first
    cdu_result_t div_results_due[$];

    int unsigned errors       = 0;
    int unsigned n_sent       = 0;
    int unsigned n_signed     = 0;
    int unsigned n_word       = 0;
    int unsigned n_zero_dvs   = 0;
    int unsigned n_checked    = 0;
    int unsigned n_overflow   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned ready_run    = 0;
    int unsigned ready_stall  = 0;

    cpu_divide_unit_8_16_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // expected quotient, remainder and overflow for one divide
    function automatic cdu_result_t predict_divide(bit sgn, bit wide,
                                                   logic [31:0] dvd_in, logic [15:0] dvs_in);
        int unsigned       n;
        longint unsigned   nmask, wmask, nsign, wsign, dvd, dvs, qu;
        longint            a, b, qs, rs;
        cdu_result_t       res;
        n     = wide ? 16 : 8;
        nmask = (64'd1 << n) - 1;
        wmask = (64'd1 << (2 * n)) - 1;
        nsign = 64'd1 << (n - 1);
        wsign = 64'd1 << (2 * n - 1);
        dvd   = dvd_in & wmask;
        dvs   = dvs_in & nmask;
        res   = '0;
        if (dvs == 0) begin
            // inverted high half as quotient, low half as remainder
            res.quotient  = 16'(~(dvd >> n) & nmask);
            res.remainder = 16'(dvd & nmask);
            res.overflow  = 1'b1;
        end else if (!sgn) begin
            qu            = dvd / dvs;
            res.quotient  = 16'(qu & nmask);
            res.remainder = 16'((dvd % dvs) & nmask);
            res.overflow  = qu > nmask;
        end else begin
            a             = longint'(dvd ^ wsign) - longint'(wsign);
            b             = longint'(dvs ^ nsign) - longint'(nsign);
            qs            = a / b;
            rs            = a % b;
            res.quotient  = 16'(qs & longint'(nmask));
            res.remainder = 16'(rs & longint'(nmask));
            res.overflow  = (qs < -longint'(nsign)) || (qs > longint'(nsign) - 1);
        end
        return res;
    endfunction

    // present one beat after an optional gap, hold it until taken
    task automatic send_divide(input bit sgn, input bit wide, input logic [31:0] dvd,
                               input logic [15:0] dvs, input cdu_result_t due,
                               input int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dvs, dvd};
        s_tuser  <= {wide, sgn};
        do @(posedge aclk); while (!s_tready);
        div_results_due.push_back(due);
        n_sent++;
        if (sgn) n_signed++;
        if (wide) n_word++;
        if ((dvs & (wide ? 16'hFFFF : 16'h00FF)) == 0) n_zero_dvs++;
    endtask

    // result side: random stalls with calm stretches between them
    always @(posedge aclk) begin
        if (ready_run > 0) begin
            m_tready  <= 1'b1;
            ready_run--;
        end else if (ready_stall > 0) begin
            m_tready  <= 1'b0;
            ready_stall--;
        end else begin
            ready_run   = ($urandom_range(0, 49) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 8);
            ready_stall = pick_gap();
            m_tready    <= 1'b1;
        end
    end

    // compare every result beat with the oldest one owed
    always @(posedge aclk) begin
        cdu_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = cdu_result_t'(m_tdata[32:0]);
            if (div_results_due.size() == 0) begin
                $display("%0t: result beat with none owed: got %h", $time, m_tdata);
                errors++;
            end else begin
                want = div_results_due.pop_front();
                n_checked++;
                if (want.overflow) n_overflow++;
                if (got.quotient !== want.quotient) begin
                    $display("%0t: quotient mismatch: expected %h, got %h",
                             $time, want.quotient, got.quotient);
                    errors++;
                end
                if (got.remainder !== want.remainder) begin
                    $display("%0t: remainder mismatch: expected %h, got %h",
                             $time, want.remainder, got.remainder);
                    errors++;
                end
                if (got.overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch: expected %b, got %b",
                             $time, want.overflow, got.overflow);
                    errors++;
                end
                if (m_tdata[39:33] !== '0) begin
                    $display("%0t: pad bits mismatch: expected 00, got %h",
                             $time, m_tdata[39:33]);
                    errors++;
                end
            end
        end
    end

    // give up once neither side has moved a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [31:0]     raw_dvd, dvd;
        logic [15:0]     raw_dvs, dvs;
        bit              sgn, wide;
        int unsigned     n, kind, sh, e, calm_left;
        longint unsigned nmask, wmask, nsign, wsign;
        longint          sval;
        calm_left = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows: typed-in answer where given, predictor otherwise
        for (int i = 0; i < N_ROWS; i++) begin
            send_divide(DIR_ROWS[i].sgn, DIR_ROWS[i].wide, DIR_ROWS[i].dvd, DIR_ROWS[i].dvs,
                        DIR_ROWS[i].has_ans ? DIR_ROWS[i].ans
                                            : predict_divide(DIR_ROWS[i].sgn,
                                                             DIR_ROWS[i].wide,
                                                             DIR_ROWS[i].dvd,
                                                             DIR_ROWS[i].dvs),
                        pick_gap());
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sgn     = $urandom_range(0, 1);
            wide    = $urandom_range(0, 1);
            n       = wide ? 16 : 8;
            nmask   = (64'd1 << n) - 1;
            wmask   = (64'd1 << (2 * n)) - 1;
            nsign   = 64'd1 << (n - 1);
            wsign   = 64'd1 << (2 * n - 1);
            raw_dvd = $urandom;
            raw_dvs = 16'($urandom);
            dvd     = raw_dvd;
            dvs     = raw_dvs;
            kind    = $urandom_range(0, 9);
            if (kind == 0) begin
                // zero divisor, upper divisor bits still random in byte mode
                dvs = 16'(raw_dvs & ~nmask);
            end else if (kind == 1) begin
                // operand extremes: zero (one for the divisor), all ones, sign bit, largest positive
                e   = $urandom_range(0, 3);
                dvd = 32'((raw_dvd & ~wmask) | ((e == 0) ? 64'd0 : (e == 1) ? wmask :
                                                (e == 2) ? wsign : wsign - 1));
                e   = $urandom_range(0, 3);
                dvs = 16'((raw_dvs & ~nmask) | ((e == 0) ? 64'd1 : (e == 1) ? nmask :
                                                (e == 2) ? nsign : nsign - 1));
            end else if (kind <= 5) begin
                // shrink the dividend so quotients land on both sides of the limit
                sh   = $urandom_range(0, 2 * n - 1);
                sval = longint'(raw_dvd & wmask);
                if (sgn && (sval & wsign) != 0) sval -= longint'(wmask) + 1;
                sval = sval >>> sh;
                dvd  = 32'((raw_dvd & ~wmask) | (sval & wmask));
            end else if (kind <= 7) begin
                // shrink the divisor, keeping its sign when signed
                sh   = $urandom_range(0, n - 1);
                sval = longint'(raw_dvs & nmask);
                if (sgn && (sval & nsign) != 0) sval -= longint'(nmask) + 1;
                sval = sval >>> sh;
                dvs  = 16'((raw_dvs & ~nmask) | (sval & nmask));
            end

            // occasional back-to-back stretches with no gaps at all
            if (calm_left == 0 && $urandom_range(0, 199) == 0)
                calm_left = $urandom_range(30, 100);
            if (calm_left > 0) begin
                calm_left--;
                send_divide(sgn, wide, dvd, dvs, predict_divide(sgn, wide, dvd, dvs), 0);
            end else begin
                send_divide(sgn, wide, dvd, dvs, predict_divide(sgn, wide, dvd, dvs),
                            pick_gap());
            end
        end
        s_tvalid <= 1'b0;

        // drain, then watch a little longer for stray beats
        while (div_results_due.size() > 0) @(posedge aclk);
        repeat (2 * DUT_LATENCY) @(posedge aclk);

        $display("%0d divides sent (%0d signed, %0d 32-by-16, %0d with zero divisor)",
                 n_sent, n_signed, n_word, n_zero_dvs);
        $display("%0d results checked, %0d of them flagged overflow, %0d errors",
                 n_checked, n_overflow, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
